// File: src/sport_pf_pkg.sv
// Shared constants, types and packet-building functions for the telemetry packet framer.
`timescale 1ns / 1ps
`default_nettype none
package sport_pf_pkg;

   localparam int PACKET_BYTES = 9;
   localparam int BYTE_W       = 8;
   localparam int PKT_W        = PACKET_BYTES * BYTE_W;
   localparam int CNT_W        = $clog2(PACKET_BYTES + 1);
   localparam int ID_W         = 5;
   localparam int FTYPE_W      = 8;
   localparam int APP_W        = 16;
   localparam int DATA_W       = 32;
   // Bytes 1 to 7 summed as plain integers need three bits above the byte.
   localparam int SUM_W        = BYTE_W + 3;
   localparam int BODY_BYTES   = PACKET_BYTES - 2;

   localparam logic [ID_W-1:0]   MAX_SENSOR_ID = ID_W'(8'h1B);
   localparam logic [BYTE_W-1:0] CHECK_BASE    = 8'hFF;

   typedef logic [CNT_W-1:0] count_type;

   localparam count_type CNT_ONE  = count_type'(1);
   localparam count_type CNT_FULL = count_type'(PACKET_BYTES);

   // A built packet travelling from the builder to the serialiser.
   typedef struct packed {
      logic             valid;
      logic             bad;
      logic [PKT_W-1:0] bytes;
   } pkt_type;

   // Sensor id with its three parity bits in bits 7 to 5.
   function automatic logic [BYTE_W-1:0] framed_id(input logic [ID_W-1:0] id);
      logic p5;
      logic p6;
      logic p7;
      p5 = id[0] ^ id[1] ^ id[2];
      p6 = id[2] ^ id[3] ^ id[4];
      p7 = id[0] ^ id[2] ^ id[4];
      return {p7, p6, p5, id};
   endfunction

   // End-around-carry sum of the seven body bytes, subtracted from 0xFF.
   // Summing first and folding the carries back twice gives the same
   // result as folding after every byte.
   function automatic logic [BYTE_W-1:0] check_byte(
      input logic [BODY_BYTES*BYTE_W-1:0] body
   );
      logic [SUM_W-1:0]  sum;
      logic [BYTE_W:0]   fold1;
      logic [BYTE_W-1:0] fold2;
      sum = '0;
      for (int i = 0; i < BODY_BYTES; i++) begin
         sum = sum + SUM_W'(body[i*BYTE_W +: BYTE_W]);
      end
      fold1 = (BYTE_W+1)'(sum[BYTE_W-1:0]) + (BYTE_W+1)'(sum[SUM_W-1:BYTE_W]);
      fold2 = fold1[BYTE_W-1:0] + BYTE_W'(fold1[BYTE_W]);
      return CHECK_BASE - fold2;
   endfunction

endpackage
`default_nettype wire

// File: src/sport_pf_if.sv
// Valid/ready channel interfaces for the request and response sides of the framer.
`timescale 1ns / 1ps
`default_nettype none
interface sport_pf_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  sensor_id;
   logic [7:0]  frame_type;
   logic [15:0] app_id;
   logic [31:0] data_value;

   modport source (output valid, output sensor_id, output frame_type,
                   output app_id, output data_value, input ready);
   modport sink   (input valid, input sensor_id, input frame_type,
                   input app_id, input data_value, output ready);
endinterface

interface sport_pf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       bad_id;

   modport source (output valid, output out_byte, output last, output bad_id,
                   input ready);
   modport sink   (input valid, input out_byte, input last, input bad_id,
                   output ready);
endinterface
`default_nettype wire

// File: src/sport_pf_build.sv
// Input register and packet builder: captures one request and forms its nine packet bytes.
`timescale 1ns / 1ps
`default_nettype none
module sport_pf_build (
   input  logic                  clock,
   input  logic                  reset,
   sport_pf_req_if.sink          req_chan,
   output sport_pf_pkg::pkt_type pkt,
   input  logic                  pkt_take
);
   import sport_pf_pkg::*;

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [ID_W-1:0]     id_ff;
   logic [FTYPE_W-1:0]  ftype_ff;
   logic [APP_W-1:0]    app_ff;
   logic [DATA_W-1:0]   data_ff;
   logic                accept;
   logic                bad;
   logic [BYTE_W-1:0]   chk;

   assign req_chan.ready = !in_valid_ff || pkt_take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (pkt_take) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         id_ff    <= req_chan.sensor_id;
         ftype_ff <= req_chan.frame_type;
         app_ff   <= req_chan.app_id;
         data_ff  <= req_chan.data_value;
      end
   end

   assign bad = id_ff > MAX_SENSOR_ID;
   assign chk = check_byte({data_ff, app_ff, ftype_ff});

   // Byte 0 sits in the least significant position.
   always_comb begin
      pkt.valid = in_valid_ff;
      pkt.bad   = bad;
      if (bad) begin
         pkt.bytes = '0;
      end else begin
         pkt.bytes = {chk, data_ff, app_ff, ftype_ff, framed_id(id_ff)};
      end
   end

endmodule
`default_nettype wire

// File: src/sport_pf_ser.sv
// Byte serialiser: shifts a built packet out one byte per transfer through a result register.
`timescale 1ns / 1ps
`default_nettype none
module sport_pf_ser (
   input  logic                  clock,
   input  logic                  reset,
   input  sport_pf_pkg::pkt_type pkt,
   output logic                  pkt_take,
   sport_pf_rsp_if.source        rsp_chan
);
   import sport_pf_pkg::*;

   logic [PKT_W-1:0]  shift_ff;
   logic [PKT_W-1:0]  shift_in;
   count_type         count_ff;
   count_type         count_in;
   logic              bad_ff;
   logic              bad_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;
   logic              rsp_bad_ff;
   logic              out_adv;
   logic              emit;

   assign out_adv  = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = out_adv && (count_ff != '0);
   // A new packet loads when the shifter is empty or gives up its final byte now.
   assign pkt_take = pkt.valid && ((count_ff == '0) || ((count_ff == CNT_ONE) && emit));

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      bad_in   = bad_ff;
      if (pkt_take) begin
         shift_in = pkt.bytes;
         count_in = pkt.bad ? CNT_ONE : CNT_FULL;
         bad_in   = pkt.bad;
      end else if (emit) begin
         shift_in = shift_ff >> BYTE_W;
         count_in = count_ff - CNT_ONE;
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bad_ff   <= bad_in;
      if (emit) begin
         rsp_byte_ff <= shift_ff[BYTE_W-1:0];
         rsp_last_ff <= (count_ff == CNT_ONE) && !bad_ff;
         rsp_bad_ff  <= bad_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.last     = rsp_last_ff;
   assign rsp_chan.bad_id   = rsp_bad_ff;

endmodule
`default_nettype wire

// File: src/sport_packet_framer_core.sv
// Top level of the telemetry packet framer: request register, builder and byte serialiser.
//
// The request channel carries a sensor id, a frame type, an application id and a 32-bit
// value; a transfer takes place on a rising clock edge with valid and ready both high.
// Each request with an id from 0 to 27 produces nine response transfers of one byte each:
// the id with three parity bits, the frame type, the application id and the value (both
// low byte first), and finally a checksum byte, which alone carries last. A request with
// an id above 27 produces a single response with a zero byte and bad_id set.
// A request goes through the request and shift registers before its first byte reaches
// the response register. While ready is high, throughput is one response byte per cycle,
// so good requests are taken at one per nine bytes; this is set by the single byte-wide
// output register. The request register takes the next item while the serialiser still
// emits the previous packet, and the hand-over is in the same cycle as the final byte, so
// no slot is lost between packets. When the receiver holds ready low the response register
// keeps its byte, the serialiser pauses, and the request side fills and then drops ready.
// A synchronous reset empties the request register, the serialiser and the response
// register; nothing needs clearing beyond that, and requests are taken from the next cycle.
`timescale 1ns / 1ps
`default_nettype none
module sport_packet_framer_core (
   input  logic           clock,
   input  logic           reset,
   sport_pf_req_if.sink   req_chan,
   sport_pf_rsp_if.source rsp_chan
);
   import sport_pf_pkg::*;

   // Built packet between the two halves, and the serialiser's claim on it.
   pkt_type pkt;
   logic    pkt_take;

   // The builder holds one request and derives the whole packet from it combinationally.
   sport_pf_build u_build (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pkt      (pkt),
      .pkt_take (pkt_take)
   );

   // The serialiser shifts the packet out through the response register.
   sport_pf_ser u_ser (
      .clock    (clock),
      .reset    (reset),
      .pkt      (pkt),
      .pkt_take (pkt_take),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

// File: src/sport_pf_checker.sv
// Port-level checker for the telemetry packet framer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sport_pf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic       rsp_bad_id
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last) && $stable(rsp_bad_id))
      else $error("response changed while stalled");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A rejected id gives a zero byte that never closes a packet.
   a_bad_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_id |-> (rsp_out_byte == 8'h00) && !rsp_last)
      else $error("malformed rejected-id response");

   // The byte after a closing byte starts a new packet, so it cannot close one too.
   a_last_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !(rsp_valid && rsp_last))
      else $error("two closing bytes in a row");

endmodule

bind sport_packet_framer_core sport_pf_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_last     (rsp_chan.last),
   .rsp_bad_id   (rsp_chan.bad_id)
);
`default_nettype wire
